### rtl/core/lnni_pkg.sv
package lnni_pkg;

    // Field widths fixed by the interface.
    localparam int SIZE_W  = 7;
    localparam int LIN_W   = 19;
    localparam int IDX_W   = 20;
    localparam int PLANE_W = 14;
    localparam int TOTAL_W = 21;
    localparam int CK_W    = 20;

    // The linear decode is a restoring division by the plane size (one quotient bit
    // per step), followed by a division of the remainder by size_x.
    localparam int K_STEPS   = LIN_W;
    localparam int J_STEPS   = SIZE_W;
    localparam int DIV_STEPS = K_STEPS + J_STEPS;

    localparam logic CMD_COORD  = 1'b0;
    localparam logic CMD_LINEAR = 1'b1;

    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    localparam logic [1:0] KIND_INTERIOR = 2'd0;
    localparam logic [1:0] KIND_INLET    = 2'd1;
    localparam logic [1:0] KIND_OUTLET   = 2'd2;
    localparam logic [1:0] KIND_OUTSIDE  = 2'd3;

    localparam logic [2:0] DIR_I_PLUS  = 3'd0;
    localparam logic [2:0] DIR_J_PLUS  = 3'd1;
    localparam logic [2:0] DIR_K_PLUS  = 3'd2;
    localparam logic [2:0] DIR_I_MINUS = 3'd3;
    localparam logic [2:0] DIR_J_MINUS = 3'd4;
    localparam logic [2:0] DIR_K_MINUS = 3'd5;

    typedef struct packed {
        logic                command;
        logic [SIZE_W-1:0]   coord_i_in;
        logic [SIZE_W-1:0]   coord_j_in;
        logic [SIZE_W-1:0]   coord_k_in;
        logic [LIN_W-1:0]    linear_in;
        logic [2:0]          direction;
    } req_t;

    typedef struct packed {
        logic signed [IDX_W-1:0] node_index;
        logic [1:0]              node_kind;
        logic                    next_to_inlet;
        logic                    next_to_outlet;
        logic signed [IDX_W-1:0] neighbor_index;
        logic                    crosses_periodic;
        logic [SIZE_W-1:0]       coord_i_out;
        logic [SIZE_W-1:0]       coord_j_out;
        logic [SIZE_W-1:0]       coord_k_out;
        logic signed [IDX_W-1:0] export_index;
        logic                    bad_direction;
    } rsp_t;

    // Work item inside the divider pipeline.
    typedef struct packed {
        req_t                req;
        logic [LIN_W-1:0]    dividend;
        logic [PLANE_W:0]    rem;
        logic [PLANE_W-1:0]  rr;
        logic [LIN_W-1:0]    qk;
        logic [SIZE_W-1:0]   qj;
    } div_t;

endpackage

### rtl/core/lnni_div.sv
module lnni_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  lnni_pkg::div_t              up_data,
    output logic                        dn_valid,
    input  logic                        dn_ready,
    output lnni_pkg::div_t              dn_data,
    input  logic [lnni_pkg::PLANE_W-1:0] plane,
    input  logic [lnni_pkg::SIZE_W-1:0]  nx
);

    localparam int STEPS = 4;
    localparam int NS    = (lnni_pkg::DIV_STEPS + STEPS - 1) / STEPS;

    function automatic lnni_pkg::div_t div_step(lnni_pkg::div_t d, int t,
                                                logic [lnni_pkg::PLANE_W-1:0] pl,
                                                logic [lnni_pkg::SIZE_W-1:0] dx);
        lnni_pkg::div_t               o;
        logic [lnni_pkg::PLANE_W:0]   x;
        logic [lnni_pkg::PLANE_W:0]   cur;
        int                           b;
        o   = d;
        x   = '0;
        cur = '0;
        b   = 0;
        if (t < lnni_pkg::K_STEPS)
        begin
            b = lnni_pkg::K_STEPS - 1 - t;
            x = {d.rem[lnni_pkg::PLANE_W-1:0], d.dividend[b]};
            if (x >= {1'b0, pl})
            begin
                o.rem   = x - {1'b0, pl};
                o.qk[b] = 1'b1;
            end
            else
            begin
                o.rem = x;
            end
            if (t == lnni_pkg::K_STEPS - 1)
            begin
                o.rr = o.rem[lnni_pkg::PLANE_W-1:0];
            end
        end
        else if (t < lnni_pkg::DIV_STEPS)
        begin
            // The upper bits of the plane remainder are already below size_x.
            b   = lnni_pkg::DIV_STEPS - 1 - t;
            cur = (t == lnni_pkg::K_STEPS)
                ? {{(lnni_pkg::PLANE_W + 1 - (lnni_pkg::PLANE_W - lnni_pkg::SIZE_W)){1'b0}},
                   d.rr[lnni_pkg::PLANE_W-1:lnni_pkg::SIZE_W]}
                : d.rem;
            x = {cur[lnni_pkg::PLANE_W-1:0], d.rr[b]};
            if (x >= (lnni_pkg::PLANE_W + 1)'(dx))
            begin
                o.rem   = x - (lnni_pkg::PLANE_W + 1)'(dx);
                o.qj[b] = 1'b1;
            end
            else
            begin
                o.rem = x;
            end
        end
        return o;
    endfunction

    lnni_pkg::div_t  stage_reg [NS];
    logic [NS-1:0]   valid_reg;
    logic [NS:0]     rdy;

    assign rdy[NS]  = dn_ready;
    assign up_ready = rdy[0];
    assign dn_valid = valid_reg[NS-1];
    assign dn_data  = stage_reg[NS-1];

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        lnni_pkg::div_t stage_next;
        logic           prev_valid;

        assign rdy[s] = !valid_reg[s] || rdy[s+1];

        if (s == 0)
        begin : g_first
            always_comb
            begin
                stage_next = up_data;
                prev_valid = up_valid;
                for (int k = 0; k < STEPS; k++)
                begin
                    stage_next = div_step(stage_next, s * STEPS + k, plane, nx);
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                stage_next = stage_reg[s-1];
                prev_valid = valid_reg[s-1];
                for (int k = 0; k < STEPS; k++)
                begin
                    stage_next = div_step(stage_next, s * STEPS + k, plane, nx);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (rdy[s])
            begin
                valid_reg[s] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s] && prev_valid)
            begin
                stage_reg[s] <= stage_next;
            end
        end
    end

endmodule

### rtl/core/lattice_node_neighbor_index.sv
// The path from an accepted request to its result on rsp has 13 register stages.
// Throughput: one request per cycle unless rsp_stall holds it back; the plane and row
// divisions run as a 7 stage restoring divider, up to four quotient bits per stage.
// Reset: rst_n clears all stage valid bits and sets size_x, size_y and size_z to 1.
// The derived plane size is registered from the size registers, and total from plane.
module lattice_node_neighbor_index
#(
    parameter int MAX_DIM = 64
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  lnni_pkg::req_t               req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output lnni_pkg::rsp_t               rsp,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [lnni_pkg::SIZE_W-1:0]  cfg_data
);

    // Resolved coordinates and class of a node as they travel through the
    // back end of the pipeline.
    typedef struct packed {
        logic [7:0]                      ci;
        logic [7:0]                      cj;
        logic [lnni_pkg::CK_W-1:0]       ck;
        logic [1:0]                      kind;
        logic [2:0]                      dir;
        logic [lnni_pkg::TOTAL_W-1:0]    prod_k;
        logic [lnni_pkg::PLANE_W-1:0]    prod_j;
        logic [lnni_pkg::IDX_W-1:0]      idx;
        logic [lnni_pkg::IDX_W-1:0]      expi;
    } node_t;

    // A size register of zero acts as one, and sizes above MAX_DIM are clamped.
    function automatic logic [lnni_pkg::SIZE_W-1:0] eff_size(logic [lnni_pkg::SIZE_W-1:0] v);
        logic [lnni_pkg::SIZE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = lnni_pkg::SIZE_W'(1);
        end
        else if (32'(v) > MAX_DIM)
        begin
            r = lnni_pkg::SIZE_W'(MAX_DIM);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers and sizes derived from them.  The port
    // always takes a write; an index beyond the list is dropped.
    // ---------------------------------------------------------------
    logic [lnni_pkg::SIZE_W-1:0]   size_x_reg, size_y_reg, size_z_reg;
    logic [lnni_pkg::SIZE_W-1:0]   nx, ny, nz;
    logic [lnni_pkg::PLANE_W-1:0]  plane_reg;
    logic [lnni_pkg::TOTAL_W-1:0]  total_reg;
    logic [lnni_pkg::IDX_W-1:0]    row_wrap;
    logic [lnni_pkg::IDX_W-1:0]    plane_wrap;
    logic [lnni_pkg::IDX_W-1:0]    outlet_idx;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= lnni_pkg::SIZE_W'(1);
            size_y_reg <= lnni_pkg::SIZE_W'(1);
            size_z_reg <= lnni_pkg::SIZE_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lnni_pkg::REG_SIZE_X: size_x_reg <= cfg_data;
                lnni_pkg::REG_SIZE_Y: size_y_reg <= cfg_data;
                lnni_pkg::REG_SIZE_Z: size_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign nx = eff_size(size_x_reg);
    assign ny = eff_size(size_y_reg);
    assign nz = eff_size(size_z_reg);

    // The plane and total products are registered; total uses the registered plane.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= lnni_pkg::PLANE_W'(1);
            total_reg <= lnni_pkg::TOTAL_W'(1);
        end
        else
        begin
            plane_reg <= lnni_pkg::PLANE_W'(nx) * lnni_pkg::PLANE_W'(ny);
            total_reg <= lnni_pkg::TOTAL_W'(plane_reg) * lnni_pkg::TOTAL_W'(nz);
        end
    end

    // Index offsets for a periodic wrap on j and on k, and the outlet index.
    assign row_wrap   = lnni_pkg::IDX_W'(plane_reg - lnni_pkg::PLANE_W'(nx));
    assign plane_wrap = lnni_pkg::IDX_W'(total_reg - lnni_pkg::TOTAL_W'(plane_reg));
    assign outlet_idx = lnni_pkg::IDX_W'(total_reg + lnni_pkg::TOTAL_W'(1));

    // ---------------------------------------------------------------
    // Handshake: every stage moves when it is empty or the one after
    // it moves, so bubbles close up and a stall loses nothing.
    // ---------------------------------------------------------------
    logic in_valid_reg, prep_valid_reg, p1_valid_reg, p2_valid_reg, p3_valid_reg, out_valid_reg;
    logic rdy_in, rdy_prep, rdy_p1, rdy_p2, rdy_p3, rdy_out;
    logic div_up_ready, div_dn_valid;

    assign rdy_out   = !out_valid_reg || !rsp_stall;
    assign rdy_p3    = !p3_valid_reg || rdy_out;
    assign rdy_p2    = !p2_valid_reg || rdy_p3;
    assign rdy_p1    = !p1_valid_reg || rdy_p2;
    assign rdy_prep  = !prep_valid_reg || div_up_ready;
    assign rdy_in    = !in_valid_reg || rdy_prep;
    assign req_stall = !rdy_in;
    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prep_valid_reg <= 1'b0;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            p3_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (rdy_in)   in_valid_reg   <= req_valid;
            if (rdy_prep) prep_valid_reg <= in_valid_reg;
            if (rdy_p1)   p1_valid_reg   <= div_dn_valid;
            if (rdy_p2)   p2_valid_reg   <= p1_valid_reg;
            if (rdy_p3)   p3_valid_reg   <= p2_valid_reg;
            if (rdy_out)  out_valid_reg  <= p3_valid_reg;
        end
    end

    // ---------------------------------------------------------------
    // Input register and divider preparation.  The preparation stage
    // loads linear_in minus one as the dividend and clears the remainder
    // and quotients.  The divider reads the registered plane product.
    // ---------------------------------------------------------------
    lnni_pkg::req_t in_reg;
    lnni_pkg::div_t prep_reg;
    lnni_pkg::div_t div_out;

    always_ff @(posedge clk)
    begin
        if (rdy_in && req_valid)
        begin
            in_reg <= req;
        end
        if (rdy_prep && in_valid_reg)
        begin
            prep_reg.req      <= in_reg;
            prep_reg.dividend <= in_reg.linear_in - lnni_pkg::LIN_W'(1);
            prep_reg.rem      <= '0;
            prep_reg.rr       <= '0;
            prep_reg.qk       <= '0;
            prep_reg.qj       <= '0;
        end
    end

    lnni_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (prep_valid_reg),
        .up_ready (div_up_ready),
        .up_data  (prep_reg),
        .dn_valid (div_dn_valid),
        .dn_ready (rdy_p1),
        .dn_data  (div_out),
        .plane    (plane_reg),
        .nx       (nx)
    );

    // ---------------------------------------------------------------
    // Stage 1: resolve the coordinates and classify the node.  Index
    // zero is the inlet and index total+1 the outlet; other indexes use
    // the quotients and the row remainder from the divider.
    // ---------------------------------------------------------------
    node_t p1_next, p1_reg, p2_reg, p3_reg;
    node_t p2_next, p3_next;
    logic  jk_in;

    always_comb
    begin
        p1_next = '0;
        if (div_out.req.command == lnni_pkg::CMD_COORD)
        begin
            p1_next.ci = 8'(div_out.req.coord_i_in);
            p1_next.cj = 8'(div_out.req.coord_j_in);
            p1_next.ck = lnni_pkg::CK_W'(div_out.req.coord_k_in);
        end
        else if (div_out.req.linear_in == '0)
        begin
            p1_next.ci = 8'd0;
            p1_next.cj = 8'd1;
            p1_next.ck = lnni_pkg::CK_W'(1);
        end
        else if (22'(div_out.req.linear_in) == 22'(total_reg) + 22'd1)
        begin
            p1_next.ci = 8'(nx) + 8'd1;
            p1_next.cj = 8'd1;
            p1_next.ck = lnni_pkg::CK_W'(1);
        end
        else
        begin
            p1_next.ci = 8'(div_out.rem[lnni_pkg::SIZE_W-1:0]) + 8'd1;
            p1_next.cj = 8'(div_out.qj) + 8'd1;
            p1_next.ck = lnni_pkg::CK_W'(div_out.qk) + lnni_pkg::CK_W'(1);
        end
        p1_next.dir = div_out.req.direction;

        jk_in = (p1_next.cj != '0) && (p1_next.cj <= 8'(ny))
             && (p1_next.ck != '0) && (p1_next.ck <= lnni_pkg::CK_W'(nz));
        if (jk_in && (p1_next.ci != '0) && (p1_next.ci <= 8'(nx)))
        begin
            p1_next.kind = lnni_pkg::KIND_INTERIOR;
        end
        else if (jk_in && (p1_next.ci == '0))
        begin
            p1_next.kind = lnni_pkg::KIND_INLET;
        end
        else if (jk_in && (p1_next.ci == 8'(nx) + 8'd1))
        begin
            p1_next.kind = lnni_pkg::KIND_OUTLET;
        end
        else
        begin
            p1_next.kind = lnni_pkg::KIND_OUTSIDE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_p1 && div_dn_valid)
        begin
            p1_reg <= p1_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: plane and row offsets.  They only matter for an interior
    // node, where k and j fit in seven bits.
    // ---------------------------------------------------------------
    always_comb
    begin
        p2_next        = p1_reg;
        p2_next.prod_k = lnni_pkg::TOTAL_W'(p1_reg.ck[lnni_pkg::SIZE_W-1:0]
                                            - lnni_pkg::SIZE_W'(1))
                       * lnni_pkg::TOTAL_W'(plane_reg);
        p2_next.prod_j = lnni_pkg::PLANE_W'(p1_reg.cj[lnni_pkg::SIZE_W-1:0]
                                            - lnni_pkg::SIZE_W'(1))
                       * lnni_pkg::PLANE_W'(nx);
    end

    always_ff @(posedge clk)
    begin
        if (rdy_p2 && p1_valid_reg)
        begin
            p2_reg <= p2_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: node index and export index.  All index arithmetic is
    // done modulo 2^20, which is how the outputs are presented.
    // ---------------------------------------------------------------
    logic [lnni_pkg::IDX_W-1:0] idx_next, expi_next;

    always_comb
    begin
        case (p2_reg.kind)
            lnni_pkg::KIND_INTERIOR:
            begin
                idx_next  = lnni_pkg::IDX_W'(p2_reg.prod_k
                                             + lnni_pkg::TOTAL_W'(p2_reg.prod_j)
                                             + lnni_pkg::TOTAL_W'(p2_reg.ci));
                expi_next = idx_next;
            end
            lnni_pkg::KIND_INLET:
            begin
                idx_next  = '0;
                expi_next = '1;
            end
            lnni_pkg::KIND_OUTLET:
            begin
                idx_next  = outlet_idx;
                expi_next = '0;
            end
            default:
            begin
                idx_next  = '1;
                expi_next = '1;
            end
        endcase
    end

    always_comb
    begin
        p3_next      = p2_reg;
        p3_next.idx  = idx_next;
        p3_next.expi = expi_next;
    end

    always_ff @(posedge clk)
    begin
        if (rdy_p3 && p2_valid_reg)
        begin
            p3_reg <= p3_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: neighbor in the requested direction and the output
    // register.  The i axis ends at the inlet and outlet, while j and k
    // wrap around and raise the periodic flag.
    // ---------------------------------------------------------------
    lnni_pkg::rsp_t             rsp_next;
    lnni_pkg::rsp_t             rsp_reg;
    logic [lnni_pkg::IDX_W-1:0] nb;
    logic [7:0]                 nx8, ny8;
    logic [lnni_pkg::CK_W-1:0]  nzw;

    assign nx8 = 8'(nx);
    assign ny8 = 8'(ny);
    assign nzw = lnni_pkg::CK_W'(nz);

    always_comb
    begin
        rsp_next = '0;
        nb       = '1;
        unique case (p3_reg.dir)
            lnni_pkg::DIR_I_PLUS:
            begin
                if (p3_reg.ci == nx8)
                    nb = outlet_idx;
                else if ((p3_reg.ci >= 8'd1) && (p3_reg.ci < nx8))
                    nb = p3_reg.idx + lnni_pkg::IDX_W'(1);
            end
            lnni_pkg::DIR_J_PLUS:
            begin
                if (p3_reg.cj == ny8)
                begin
                    rsp_next.crosses_periodic = 1'b1;
                    nb = p3_reg.idx - row_wrap;
                end
                else if ((p3_reg.cj >= 8'd1) && (p3_reg.cj < ny8))
                    nb = p3_reg.idx + lnni_pkg::IDX_W'(nx);
            end
            lnni_pkg::DIR_K_PLUS:
            begin
                if (p3_reg.ck == nzw)
                begin
                    rsp_next.crosses_periodic = 1'b1;
                    nb = p3_reg.idx - plane_wrap;
                end
                else if ((p3_reg.ck >= lnni_pkg::CK_W'(1)) && (p3_reg.ck < nzw))
                    nb = p3_reg.idx + lnni_pkg::IDX_W'(plane_reg);
            end
            lnni_pkg::DIR_I_MINUS:
            begin
                if (p3_reg.ci == 8'd1)
                    nb = '0;
                else if ((p3_reg.ci > 8'd1) && (p3_reg.ci <= nx8))
                    nb = p3_reg.idx - lnni_pkg::IDX_W'(1);
            end
            lnni_pkg::DIR_J_MINUS:
            begin
                if (p3_reg.cj == 8'd1)
                begin
                    rsp_next.crosses_periodic = 1'b1;
                    nb = p3_reg.idx + row_wrap;
                end
                else if ((p3_reg.cj > 8'd1) && (p3_reg.cj <= ny8))
                    nb = p3_reg.idx - lnni_pkg::IDX_W'(nx);
            end
            lnni_pkg::DIR_K_MINUS:
            begin
                if (p3_reg.ck == lnni_pkg::CK_W'(1))
                begin
                    rsp_next.crosses_periodic = 1'b1;
                    nb = p3_reg.idx + plane_wrap;
                end
                else if ((p3_reg.ck > lnni_pkg::CK_W'(1)) && (p3_reg.ck <= nzw))
                    nb = p3_reg.idx - lnni_pkg::IDX_W'(plane_reg);
            end
            default:
            begin
                rsp_next.bad_direction = 1'b1;
            end
        endcase

        rsp_next.node_index     = p3_reg.idx;
        rsp_next.node_kind      = p3_reg.kind;
        rsp_next.next_to_inlet  = (p3_reg.kind == lnni_pkg::KIND_INTERIOR) && (p3_reg.ci == 8'd1);
        rsp_next.next_to_outlet = (p3_reg.kind == lnni_pkg::KIND_INTERIOR) && (p3_reg.ci == nx8);
        rsp_next.neighbor_index = nb;
        rsp_next.export_index   = p3_reg.expi;
        // Coordinates above 127 are shown as 127; such a node is outside.
        rsp_next.coord_i_out = (p3_reg.ci > 8'd127) ? 7'd127 : p3_reg.ci[6:0];
        rsp_next.coord_j_out = (p3_reg.cj > 8'd127) ? 7'd127 : p3_reg.cj[6:0];
        rsp_next.coord_k_out = (p3_reg.ck > lnni_pkg::CK_W'(127)) ? 7'd127 : p3_reg.ck[6:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy_out && p3_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

    // ---------------------------------------------------------------
    // Checks on the result logic.
    // ---------------------------------------------------------------
    a_bad_dir_no_neighbor: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.bad_direction |-> (rsp.neighbor_index == '1) && !rsp.crosses_periodic)
        else $error("bad direction produced a neighbor");

    a_outside_index: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.node_kind == lnni_pkg::KIND_OUTSIDE)
        |-> (rsp.node_index == '1) && (rsp.export_index == '1))
        else $error("outside node carries an index");

    a_inlet_export: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.node_kind == lnni_pkg::KIND_INLET)
        |-> (rsp.node_index == '0) && (rsp.export_index == '1) && (rsp.coord_i_out == '0))
        else $error("inlet node indexes wrong");

    a_adjacent_interior: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.next_to_inlet || rsp.next_to_outlet)
        |-> (rsp.node_kind == lnni_pkg::KIND_INTERIOR))
        else $error("adjacency flag on a non-interior node");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_DIM     = 64;
    // Cycles without any accepted request or result before the run is declared hung.
    localparam int STALL_LIMIT = 5000;
    // Pipeline depth plus margin, used before register writes and at the end.
    localparam int DRAIN_WAIT  = 40;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    lnni_pkg::req_t req;
    logic rsp_valid;
    logic rsp_stall;
    lnni_pkg::rsp_t rsp;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [lnni_pkg::SIZE_W-1:0] cfg_data;

    lattice_node_neighbor_index #(.MAX_DIM(MAX_DIM)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Our own copy of the three size registers, as written to the block.
    logic [lnni_pkg::SIZE_W-1:0] size_x_reg;
    logic [lnni_pkg::SIZE_W-1:0] size_y_reg;
    logic [lnni_pkg::SIZE_W-1:0] size_z_reg;

    // Results still owed by the block, oldest first.
    lnni_pkg::rsp_t pending_nodes[$];
    int   mismatch_count;
    int   idle_cycles;
    bit   rx_long_stall;

    // A size register of 0 behaves as 1, and anything above MAX_DIM is clamped.
    function automatic longint clamp_size(logic [lnni_pkg::SIZE_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return longint'(v);
    endfunction

    function automatic logic [lnni_pkg::SIZE_W-1:0] sat_coord(longint v);
        if (v < 0)
            return '0;
        if (v > 127)
            return 7'd127;
        return v[lnni_pkg::SIZE_W-1:0];
    endfunction

    // Resolve the node, classify it and find its neighbor in the requested direction.
    function automatic lnni_pkg::rsp_t resolve_node(lnni_pkg::req_t r);
        longint nx;
        longint ny;
        longint nz;
        longint plane;
        longint total;
        longint ci;
        longint cj;
        longint ck;
        longint idx;
        longint nb;
        longint exp_idx;
        longint n;
        longint rem;
        bit jk_in;
        lnni_pkg::rsp_t o;
        nx = clamp_size(size_x_reg);
        ny = clamp_size(size_y_reg);
        nz = clamp_size(size_z_reg);
        plane = nx * ny;
        total = plane * nz;
        nb = -1;
        o = '0;
        if (r.command == lnni_pkg::CMD_COORD)
        begin
            ci = longint'(r.coord_i_in);
            cj = longint'(r.coord_j_in);
            ck = longint'(r.coord_k_in);
        end
        else
        begin
            n = longint'(r.linear_in);
            if (n == 0)
            begin
                ci = 0;
                cj = 1;
                ck = 1;
            end
            else if (n == total + 1)
            begin
                ci = nx + 1;
                cj = 1;
                ck = 1;
            end
            else
            begin
                rem = n - 1;
                ck = rem / plane + 1;
                rem = rem - (ck - 1) * plane;
                cj = rem / nx + 1;
                ci = rem - (cj - 1) * nx + 1;
            end
        end

        jk_in = cj > 0 && cj <= ny && ck > 0 && ck <= nz;
        if (jk_in && ci > 0 && ci <= nx)
        begin
            o.node_kind = lnni_pkg::KIND_INTERIOR;
            o.next_to_inlet = (ci == 1);
            o.next_to_outlet = (ci == nx);
            idx = (ck - 1) * plane + (cj - 1) * nx + ci;
            exp_idx = idx;
        end
        else if (jk_in && ci == 0)
        begin
            o.node_kind = lnni_pkg::KIND_INLET;
            idx = 0;
            exp_idx = -1;
        end
        else if (jk_in && ci == nx + 1)
        begin
            o.node_kind = lnni_pkg::KIND_OUTLET;
            idx = total + 1;
            exp_idx = 0;
        end
        else
        begin
            o.node_kind = lnni_pkg::KIND_OUTSIDE;
            idx = -1;
            exp_idx = -1;
        end

        // The neighbor rules look only at the coordinate of the axis moved along,
        // so inlet, outlet and outside nodes get neighbors from their own index too.
        case (r.direction)
            lnni_pkg::DIR_I_PLUS:
                if (ci == nx)
                    nb = total + 1;
                else if (ci >= 1 && ci < nx)
                    nb = idx + 1;
            lnni_pkg::DIR_J_PLUS:
                if (cj == ny)
                begin
                    o.crosses_periodic = 1'b1;
                    nb = idx - nx * (ny - 1);
                end
                else if (cj >= 1 && cj < ny)
                    nb = idx + nx;
            lnni_pkg::DIR_K_PLUS:
                if (ck == nz)
                begin
                    o.crosses_periodic = 1'b1;
                    nb = idx - plane * (nz - 1);
                end
                else if (ck >= 1 && ck < nz)
                    nb = idx + plane;
            lnni_pkg::DIR_I_MINUS:
                if (ci == 1)
                    nb = 0;
                else if (ci > 1 && ci <= nx)
                    nb = idx - 1;
            lnni_pkg::DIR_J_MINUS:
                if (cj == 1)
                begin
                    o.crosses_periodic = 1'b1;
                    nb = idx + nx * (ny - 1);
                end
                else if (cj > 1 && cj <= ny)
                    nb = idx - nx;
            lnni_pkg::DIR_K_MINUS:
                if (ck == 1)
                begin
                    o.crosses_periodic = 1'b1;
                    nb = idx + plane * (nz - 1);
                end
                else if (ck > 1 && ck <= nz)
                    nb = idx - plane;
            default:
                o.bad_direction = 1'b1;
        endcase

        o.node_index = idx[lnni_pkg::IDX_W-1:0];
        o.neighbor_index = nb[lnni_pkg::IDX_W-1:0];
        o.export_index = exp_idx[lnni_pkg::IDX_W-1:0];
        o.coord_i_out = sat_coord(ci);
        o.coord_j_out = sat_coord(cj);
        o.coord_k_out = sat_coord(ck);
        return o;
    endfunction

    // Gap length between requests or stall stretches: mostly short, sometimes long.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver side: stall changes on falling edges, with stretches of no stalling.
    initial
    begin
        int hold;
        rsp_stall = 1'b0;
        rx_long_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 199) == 0)
                rx_long_stall = !rx_long_stall;
            hold = rx_long_stall ? 0 : gap_length();
            rsp_stall <= (hold != 0);
            repeat (hold > 0 ? hold - 1 : 0)
                @(negedge clk);
        end
    end

    // Result checker and hang watchdog, both on the rising edge.
    always @(posedge clk)
    begin
        lnni_pkg::rsp_t want;
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_nodes.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("unexpected result %p", rsp);
                end
                else
                begin
                    want = pending_nodes.pop_front();
                    // A packed compare covers every field; the dump names each one.
                    if (rsp !== want)
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %p got %p", want, rsp);
                    end
                end
            end
        end
    end

    // Write one size register while the block is idle; valid stays high for the
    // caller to drop after the last write.
    task automatic write_size(logic [1:0] index, logic [lnni_pkg::SIZE_W-1:0] value);
        cfg_index <= index;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            lnni_pkg::REG_SIZE_X: size_x_reg = value;
            lnni_pkg::REG_SIZE_Y: size_y_reg = value;
            default: size_z_reg = value;
        endcase
        @(negedge clk);
    endtask

    // Stop offering requests, let every owed result come back, then let the
    // pipeline empty.
    task automatic drain_block();
        req_valid <= 1'b0;
        while (pending_nodes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT)
            @(negedge clk);
    endtask

    task automatic set_sizes(int sx, int sy, int sz);
        drain_block();
        write_size(lnni_pkg::REG_SIZE_X, lnni_pkg::SIZE_W'(sx));
        write_size(lnni_pkg::REG_SIZE_Y, lnni_pkg::SIZE_W'(sy));
        write_size(lnni_pkg::REG_SIZE_Z, lnni_pkg::SIZE_W'(sz));
        cfg_valid <= 1'b0;
        // Wait for the registered plane and total sizes to settle.
        repeat (4)
            @(negedge clk);
    endtask

    // Present one request, hold it until accepted, and record its expected result.
    // Valid stays high across back-to-back requests; it drops only for a gap.
    task automatic send_request(lnni_pkg::req_t r, bit use_typed, lnni_pkg::rsp_t typed);
        int gap;
        gap = gap_length();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_nodes.push_back(use_typed ? typed : resolve_node(r));
        @(negedge clk);
    endtask

    function automatic lnni_pkg::req_t coord_req(int i, int j, int k, logic [2:0] d);
        lnni_pkg::req_t r;
        r = '0;
        r.command = lnni_pkg::CMD_COORD;
        r.coord_i_in = lnni_pkg::SIZE_W'(i);
        r.coord_j_in = lnni_pkg::SIZE_W'(j);
        r.coord_k_in = lnni_pkg::SIZE_W'(k);
        r.direction = d;
        return r;
    endfunction

    function automatic lnni_pkg::req_t linear_req(int n, logic [2:0] d);
        lnni_pkg::req_t r;
        r = '0;
        r.command = lnni_pkg::CMD_LINEAR;
        r.linear_in = lnni_pkg::LIN_W'(n);
        r.direction = d;
        return r;
    endfunction

    // Random request: mostly nodes in or next to the lattice, with random junk
    // in the unused fields so every input bit toggles.
    function automatic lnni_pkg::req_t random_req();
        lnni_pkg::req_t r;
        logic [63:0] junk;
        int nxi;
        int nyi;
        int nzi;
        int total;
        int roll;
        nxi = int'(clamp_size(size_x_reg));
        nyi = int'(clamp_size(size_y_reg));
        nzi = int'(clamp_size(size_z_reg));
        total = nxi * nyi * nzi;
        junk = {$urandom, $urandom};
        r = junk[$bits(lnni_pkg::req_t)-1:0];
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 9) != 0)
            r.direction = 3'($urandom_range(0, 5));
        if (roll < 40)
        begin
            r.command = lnni_pkg::CMD_COORD;
            r.coord_i_in = lnni_pkg::SIZE_W'($urandom_range(0, nxi + 1));
            r.coord_j_in = lnni_pkg::SIZE_W'($urandom_range(0, nyi + 1));
            r.coord_k_in = lnni_pkg::SIZE_W'($urandom_range(0, nzi + 1));
        end
        else if (roll < 85)
        begin
            r.command = lnni_pkg::CMD_LINEAR;
            r.linear_in = lnni_pkg::LIN_W'($urandom_range(0, total + 1));
        end
        else if (roll < 92)
            r.command = lnni_pkg::CMD_COORD;
        else
        begin
            r.command = lnni_pkg::CMD_LINEAR;
            r.linear_in = lnni_pkg::LIN_W'($urandom_range(0, 262145));
        end
        return r;
    endfunction

    typedef struct {
        lnni_pkg::req_t r;
        bit             typed;
        lnni_pkg::rsp_t result;
    } stim_row_t;

    initial
    begin
        stim_row_t rows[$];
        stim_row_t row;
        lnni_pkg::rsp_t inlet_rsp;
        int rand_count;
        int phase;

        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_index = lnni_pkg::REG_SIZE_X;
        cfg_data = '0;
        size_x_reg = 1;
        size_y_reg = 1;
        size_z_reg = 1;
        mismatch_count = 0;
        idle_cycles = 0;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (4)
            @(negedge clk);

        // Right after reset the lattice is one node; the inlet is index 0 and its
        // i- step has no neighbor.
        inlet_rsp = '0;
        inlet_rsp.node_index = '0;
        inlet_rsp.node_kind = lnni_pkg::KIND_INLET;
        inlet_rsp.neighbor_index = '1;
        inlet_rsp.coord_j_out = 7'd1;
        inlet_rsp.coord_k_out = 7'd1;
        inlet_rsp.export_index = '1;
        row.r = linear_req(0, lnni_pkg::DIR_I_MINUS);
        row.typed = 1'b1;
        row.result = inlet_rsp;
        rows.push_back(row);
        row.typed = 1'b0;
        row.r = coord_req(1, 1, 1, lnni_pkg::DIR_I_PLUS);  rows.push_back(row);
        row.r = linear_req(2, lnni_pkg::DIR_I_MINUS);      rows.push_back(row);
        row.r = coord_req(127, 127, 127, 3'd7);            rows.push_back(row);
        foreach (rows[n])
            send_request(rows[n].r, rows[n].typed, rows[n].result);
        rows.delete();

        // Directed walk on a 4x3x5 lattice: every direction, wraps, inlet, outlet,
        // beyond the outlet, invalid directions and outside nodes.
        set_sizes(4, 3, 5);
        row.typed = 1'b0;
        for (int d = 0; d < 8; d++)
        begin
            row.r = coord_req(1, 1, 1, 3'(d));
            rows.push_back(row);
        end
        for (int d = 0; d < 6; d++)
        begin
            row.r = coord_req(4, 3, 5, 3'(d));
            rows.push_back(row);
        end
        row.r = linear_req(61, lnni_pkg::DIR_I_MINUS);     rows.push_back(row);
        row.r = linear_req(61, lnni_pkg::DIR_J_PLUS);      rows.push_back(row);
        row.r = linear_req(62, lnni_pkg::DIR_K_PLUS);      rows.push_back(row);
        row.r = linear_req(524287, lnni_pkg::DIR_I_PLUS);  rows.push_back(row);
        row.r = coord_req(0, 0, 0, lnni_pkg::DIR_K_MINUS); rows.push_back(row);
        row.r = coord_req(5, 2, 2, 3'd6);                  rows.push_back(row);
        foreach (rows[n])
            send_request(rows[n].r, rows[n].typed, rows[n].result);
        rows.delete();

        // Random phases over several sizes, including 0 (acts as 1), the maximum,
        // and values above the maximum that are clamped.
        rand_count = 0;
        for (phase = 0; phase < 9; phase++)
        begin
            case (phase)
                0: set_sizes(0, 0, 0);
                1: set_sizes(64, 64, 64);
                2: set_sizes(127, 1, 127);
                3: set_sizes(1, 127, 2);
                4: set_sizes(65, 100, 64);
                default: set_sizes($urandom_range(1, 9), $urandom_range(1, 9),
                                   $urandom_range(1, 9));
            endcase
            for (int n = 0; n < 50; n++)
            begin
                send_request(random_req(), 1'b0, '0);
                rand_count = rand_count + 1;
            end
        end

        drain_block();
        if (mismatch_count == 0 && pending_nodes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
